### rtl/edu_pkg.sv
// ----------------------------------------------------------------------------
// edu_pkg
// Shared word types, field widths and control structs for the distance unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edu_pkg;

  localparam int unsigned ELEM_W = 8;
  localparam int unsigned DIST_W = 21;
  localparam int unsigned SUM_W  = 26;
  // fractional bits of the root, radicand is shifted by twice this
  localparam int unsigned FRAC_W = 8;

  typedef struct packed {
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
    logic              last_elem;
  } edu_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q8;
    logic [SUM_W-1:0]  sum_squares;
    logic              overflow;
  } edu_out_t;

  typedef struct packed {
    logic take;       // accept one input word
    logic root_step;  // one root digit
    logic out_load;   // move result into the output register
  } edu_cmd_t;

  typedef struct packed {
    logic in_last;    // input word carries the last mark
    logic root_last;  // final root digit in progress
  } edu_sts_t;

endpackage

`default_nettype wire

### rtl/edu_ctrl.sv
// ----------------------------------------------------------------------------
// edu_ctrl
// Sequencer: accumulate, run the square root, hand the result out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edu_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire edu_pkg::edu_sts_t sts_i,
  output edu_pkg::edu_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_ACC  = 3'b001,
    ST_ROOT = 3'b010,
    ST_EMIT = 3'b100
  } edu_state_e;

  edu_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_ACC: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.in_last) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/edu_datapath.sv
// ----------------------------------------------------------------------------
// edu_datapath
// Squared-difference accumulator, digit-serial square root, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edu_datapath #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire edu_pkg::edu_in_t  in_data_i,
  input  wire edu_pkg::edu_cmd_t cmd_i,
  output edu_pkg::edu_sts_t      sts_o,
  output edu_pkg::edu_out_t      out_data_o
);

  localparam longint unsigned ELEM_MAX = (64'd1 << edu_pkg::ELEM_W) - 64'd1;
  localparam longint unsigned SQ_MAX   = ELEM_MAX * ELEM_MAX;
  localparam longint unsigned SUM_MAX  = longint'(MAX_LEN) * SQ_MAX;
  localparam int unsigned     ACC_W    = $clog2(SUM_MAX + SQ_MAX + 64'd1);
  localparam int unsigned     CNT_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned     RAD_IN_W = ACC_W + 2 * edu_pkg::FRAC_W;
  localparam int unsigned     ROOT_W   = (RAD_IN_W + 1) / 2;
  localparam int unsigned     RAD_W    = 2 * ROOT_W;
  localparam int unsigned     REM_W    = ROOT_W + 3;
  localparam int unsigned     STEP_W   = $clog2(ROOT_W);
  localparam int unsigned     SQ_W     = 2 * edu_pkg::ELEM_W;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [ACC_W-1:0]  sum_res_q;
  logic              ovf_res_q;

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [STEP_W-1:0] step_q;

  edu_pkg::edu_out_t out_q;

  logic [edu_pkg::ELEM_W-1:0] diff;
  logic [SQ_W-1:0]            sq;
  logic [ACC_W-1:0]           sum;

  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic             fits;

  // squared difference and saturating accumulate
  always_comb begin
    diff = (in_data_i.elem_a >= in_data_i.elem_b) ?
           (in_data_i.elem_a - in_data_i.elem_b) : (in_data_i.elem_b - in_data_i.elem_a);
    sq   = SQ_W'(diff) * SQ_W'(diff);
    sum  = acc_q + ACC_W'(sq);
    if (cnt_q == CNT_W'(MAX_LEN)) begin
      cnt_d = cnt_q;
      ovf_d = 1'b1;
      acc_d = ACC_W'(SUM_MAX);
    end else begin
      cnt_d = cnt_q + CNT_W'(1);
      ovf_d = ovf_q;
      acc_d = (sum > ACC_W'(SUM_MAX)) ? ACC_W'(SUM_MAX) : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.take) begin
      if (in_data_i.last_elem) begin
        acc_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

  // restoring root, two radicand bits per step
  always_comb begin
    rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
    fits      = rem_shift >= trial;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_data_i.last_elem) begin
      sum_res_q <= acc_d;
      ovf_res_q <= ovf_d;
      rad_q     <= RAD_W'({acc_d, {(2 * edu_pkg::FRAC_W){1'b0}}});
      rem_q     <= '0;
      root_q    <= '0;
      step_q    <= STEP_W'(ROOT_W - 1);
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? (rem_shift - trial) : rem_shift;
      root_q <= {root_q[ROOT_W-2:0], fits};
      step_q <= step_q - STEP_W'(1);
    end
    if (cmd_i.out_load) begin
      out_q.distance_q8 <= edu_pkg::DIST_W'(root_q);
      out_q.sum_squares <= edu_pkg::SUM_W'(sum_res_q);
      out_q.overflow    <= ovf_res_q;
    end
  end

  assign sts_o.in_last   = in_data_i.last_elem;
  assign sts_o.root_last = (step_q == '0);
  assign out_data_o      = out_q;

endmodule

`default_nettype wire

### rtl/euclidean_distance_unit.sv
// result: the last word of a vector starts a serial root of ROOT_W bits, then its result is loaded
//   into the output register; ROOT_W = ceil((clog2(SUM_MAX + 255^2 + 1) + 16) / 2), 21 at the default MAX_LEN
// throughput: one word per cycle within a vector; after each last word the input
//   stalls while the serial root unit produces one bit a cycle and until the result is loaded
// reset: asynchronous active low, clears accumulator, count, flag, state and output valid
// ----------------------------------------------------------------------------
// euclidean_distance_unit
// Streaming sum of squared differences with truncated Q8 square root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module euclidean_distance_unit #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire edu_pkg::edu_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output edu_pkg::edu_out_t     out_data_o
);

  edu_pkg::edu_cmd_t cmd;
  edu_pkg::edu_sts_t sts;

  edu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  edu_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/edu_checker.sv
// ----------------------------------------------------------------------------
// edu_checker
// Port-level checks of the distance unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edu_checker #(
  parameter int unsigned MAX_LEN = 1024
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire edu_pkg::edu_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire edu_pkg::edu_out_t out_data_o
);

  localparam longint unsigned ELEM_MAX = (64'd1 << edu_pkg::ELEM_W) - 64'd1;
  localparam longint unsigned SUM_MAX  = longint'(MAX_LEN) * ELEM_MAX * ELEM_MAX;

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // root runs after a last word, so input stalls
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_elem |=> in_stall_o)
    else $error("input taken during root");

  // a new result only comes out of the stalled emit phase
  a_result_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without root phase");

  // overflowed vectors report the saturated sum
  a_overflow_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.sum_squares == edu_pkg::SUM_W'(SUM_MAX))
    else $error("overflow without saturated sum");

endmodule

bind euclidean_distance_unit edu_checker #(
  .MAX_LEN (MAX_LEN)
) u_edu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming Euclidean distance unit
//
// Drives element pairs as words on the valid/stall input channel and checks
// every result word against a local model of the accumulator, the element
// count, the overflow flag and the Q8 integer square root, or a typed result
// from the table. A short table of directed words comes first, then random
// vectors with one full-scale vector that runs past MAX_LEN. Both channels
// idle in random bursts, the receiver once holds off long enough to back up
// the input, and the sender once waits for the block to drain.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned ELEM_MAX     = (1 << edu_pkg::ELEM_W) - 1;
  localparam int unsigned SUM_MAX      = MAX_LEN * ELEM_MAX * ELEM_MAX;
  localparam int unsigned RAND_WORDS   = 1400;
  localparam int unsigned CALM_WORDS   = 150;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DIR_ROWS     = 21;

  typedef enum int unsigned {
    FL_RANDOM,
    FL_EXTREME,
    FL_CLOSE,
    FL_FULL
  } flavour_e;

  typedef struct {
    edu_pkg::edu_in_t  word;
    bit                typed;
    edu_pkg::edu_out_t res;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  edu_pkg::edu_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  edu_pkg::edu_out_t out_data_o;

  // local copy of the block state
  logic [26:0] sq_acc;
  logic [10:0] pair_cnt;
  bit          sat_seen;

  edu_pkg::edu_out_t dist_due_q [$];
  int unsigned       mismatch_cnt;
  int unsigned       cycle_cnt;
  int unsigned       words_sent;
  bit                idle_on;
  bit                hold_req;

  // typed results only where they follow at a glance
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{8'd0,   8'd0,   1'b1}, 1'b1, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd255, 8'd0,   1'b1}, 1'b1, '{21'd65280, 26'd65025, 1'b0}},
    '{'{8'd0,   8'd255, 1'b1}, 1'b1, '{21'd65280, 26'd65025, 1'b0}},
    '{'{8'd255, 8'd255, 1'b1}, 1'b1, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd1,   8'd0,   1'b1}, 1'b1, '{21'd256,   26'd1,     1'b0}},
    '{'{8'd0,   8'd2,   1'b1}, 1'b1, '{21'd512,   26'd4,     1'b0}},
    '{'{8'd3,   8'd0,   1'b1}, 1'b1, '{21'd768,   26'd9,     1'b0}},
    '{'{8'd10,  8'd7,   1'b0}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd0,   8'd4,   1'b0}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd5,   8'd5,   1'b1}, 1'b1, '{21'd1280,  26'd25,    1'b0}},
    '{'{8'd255, 8'd0,   1'b0}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd0,   8'd255, 1'b1}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd200, 8'd100, 1'b0}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd17,  8'd230, 1'b0}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd128, 8'd127, 1'b1}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd85,  8'd170, 1'b1}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd170, 8'd85,  1'b0}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd15,  8'd240, 1'b0}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd240, 8'd15,  1'b1}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd1,   8'd2,   1'b1}, 1'b0, '{21'd0,     26'd0,     1'b0}},
    '{'{8'd254, 8'd1,   1'b1}, 1'b0, '{21'd0,     26'd0,     1'b0}}
  };

  euclidean_distance_unit #(
    .MAX_LEN(MAX_LEN)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // floor square root, two radicand bits per digit
  function automatic logic [edu_pkg::DIST_W-1:0] root_q8(
    input logic [2*edu_pkg::DIST_W-1:0] rad);
    logic [43:0] rem;
    logic [43:0] trial;
    logic [43:0] root;
    rem  = '0;
    root = '0;
    for (int i = edu_pkg::DIST_W - 1; i >= 0; i--) begin
      rem   = (rem << 2) | 44'(rad[2*i+1 -: 2]);
      trial = (root << 2) | 44'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 44'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[edu_pkg::DIST_W-1:0];
  endfunction

  // adds one pair to the running sum, returns 1 when a result word is due
  function automatic bit fold_pair(input edu_pkg::edu_in_t w, output edu_pkg::edu_out_t r);
    logic [edu_pkg::ELEM_W-1:0]   diff;
    logic [2*edu_pkg::ELEM_W-1:0] sq;
    diff = (w.elem_a >= w.elem_b) ? w.elem_a - w.elem_b : w.elem_b - w.elem_a;
    sq   = 16'(diff) * 16'(diff);
    r    = '0;
    if (pair_cnt >= 11'(MAX_LEN)) begin
      sat_seen = 1'b1;
      sq_acc   = 27'(SUM_MAX);
    end else begin
      pair_cnt = pair_cnt + 11'd1;
      sq_acc   = sq_acc + 27'(sq);
      if (sq_acc > 27'(SUM_MAX)) sq_acc = 27'(SUM_MAX);
    end
    if (!w.last_elem) return 1'b0;
    r.distance_q8 = root_q8({sq_acc[edu_pkg::SUM_W-1:0], 16'd0});
    r.sum_squares = sq_acc[edu_pkg::SUM_W-1:0];
    r.overflow    = sat_seen;
    sq_acc   = '0;
    pair_cnt = '0;
    sat_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic void cmp_field(input string fname, input longint unsigned want,
                                    input longint unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  task automatic send_word(input edu_pkg::edu_in_t w, input bit typed,
                           input edu_pkg::edu_out_t typed_res);
    edu_pkg::edu_out_t r;
    bit                due;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    due = fold_pair(w, r);
    if (due) dist_due_q = {dist_due_q, (typed ? typed_res : r)};
  endtask

  task automatic send_vector(input int unsigned len, input flavour_e flavour);
    edu_pkg::edu_in_t w;
    for (int unsigned i = 0; i < len; i++) begin
      w.elem_a = 8'($urandom_range(0, 255));
      case (flavour)
        FL_EXTREME: begin
          w.elem_a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          w.elem_b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        FL_CLOSE: begin
          w.elem_b = w.elem_a ^ 8'($urandom_range(0, 3));
        end
        FL_FULL: begin
          w.elem_a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          w.elem_b = ~w.elem_a;
        end
        default: begin
          w.elem_b = 8'($urandom_range(0, 255));
        end
      endcase
      w.last_elem = (i == len - 1);
      send_word(w, 1'b0, '0);
      words_sent++;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    sq_acc       = '0;
    pair_cnt     = '0;
    sat_seen     = 1'b0;
    mismatch_cnt = 0;
    words_sent   = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  end

  // sender
  initial begin
    int unsigned vec_no;
    int unsigned len;
    @(posedge rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);

    vec_no = 0;
    while (words_sent < RAND_WORDS) begin
      // stretches with and without idling, none towards the end
      idle_on = (words_sent + CALM_WORDS < RAND_WORDS) && (vec_no % 16 < 12);
      if (vec_no == 10) hold_req = 1'b1;
      if (vec_no == 25) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (dist_due_q.size() != 0);
      end
      if (vec_no == 40) begin
        // saturates exactly at the last counted element, then overflows
        send_vector(MAX_LEN + 1 + $urandom_range(0, 2), FL_FULL);
      end else begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(17, 64);
          1, 2, 3: len = $urandom_range(5, 16);
          default: len = $urandom_range(1, 4);
        endcase
        send_vector(len, flavour_e'($urandom_range(FL_RANDOM, FL_CLOSE)));
      end
      vec_no++;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (dist_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && dist_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver stall
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    edu_pkg::edu_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dist_due_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result expected none, got %0d/%0d/%0d", $time,
                 out_data_o.distance_q8, out_data_o.sum_squares, out_data_o.overflow);
      end else begin
        want = dist_due_q.pop_front();
        cmp_field("distance_q8", want.distance_q8, out_data_o.distance_q8);
        cmp_field("sum_squares", want.sum_squares, out_data_o.sum_squares);
        cmp_field("overflow", want.overflow, out_data_o.overflow);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
